// ----- hw/rtl/dmxt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmxt_pkg
// Types and constants shared by the DMX512 transmitter modules.
// ----------------------------------------------------------------------------
package dmxt_pkg;

    // item modes
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_RGB   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] REG_BREAK_BITS = 2'd0;
    localparam logic [1:0] REG_MAB_BITS   = 2'd1;

    // slot framing: start bit, 8 data bits, 2 stop bits
    localparam int         SLOT_W    = 11;
    localparam logic [7:0] SLOT_BITS = 8'd11;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] address;
        logic [7:0] level;
        logic [7:0] green;
        logic [7:0] blue;
    } dmxt_item_t;

    typedef struct packed {
        logic tx_line;
        logic drive_enable;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } dmxt_result_t;

    // commands from the item controller to the frame sequencer
    typedef struct packed {
        logic start;
        logic tick;
    } dmxt_frame_ctl_t;

    // status from the frame sequencer
    typedef struct packed {
        logic busy;
        logic line;
        logic enable;
        logic done;
    } dmxt_frame_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dmxt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmxt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmxt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dmxt_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmxt_frame
// Frame sequencer: break, mark-after-break and slot bits, one bit per tick,
// with the slot shifted out of an 11-bit shift register.
// ----------------------------------------------------------------------------
module dmxt_frame #(
    parameter int CHANNELS = 512,
    parameter int ADDR_W   = 9,
    parameter int IDX_W    = 10
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire dmxt_pkg::dmxt_frame_ctl_t  ctl,
    input  wire logic [7:0]                 break_bits,
    input  wire logic [7:0]                 mab_bits,
    input  wire logic [7:0]                 rd_data,
    output logic      [ADDR_W-1:0]          rd_addr,
    output dmxt_pkg::dmxt_frame_stat_t      stat
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_BREAK = 4'b0010,
        PH_MAB   = 4'b0100,
        PH_SLOTS = 4'b1000
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  bit_count_reg, bit_count_next;
    logic [IDX_W-1:0]            slot_index_reg, slot_index_next;
    logic [dmxt_pkg::SLOT_W-1:0] slot_shift_reg, slot_shift_next;
    logic                        enable_reg, enable_next;
    logic                        done_reg, done_next;
    logic                        busy;
    logic                        last_bit;
    logic [7:0]                  break_len;
    logic [7:0]                  mab_len;

    assign busy      = (phase_reg != PH_IDLE);
    assign last_bit  = (bit_count_reg <= 8'd1);
    // a zero length acts as one bit time
    assign break_len = (break_bits == 8'd0) ? 8'd1 : break_bits;
    assign mab_len   = (mab_bits == 8'd0) ? 8'd1 : mab_bits;

    // the slot to load next is channel slot_index + 1, stored at slot_index
    assign rd_addr = (slot_index_reg < IDX_W'(CHANNELS)) ? slot_index_reg[ADDR_W-1:0] : '0;

    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        slot_index_next = slot_index_reg;
        slot_shift_next = slot_shift_reg;
        enable_next     = enable_reg;
        done_next       = done_reg;
        if (ctl.start) begin
            phase_next     = PH_BREAK;
            bit_count_next = break_len;
            enable_next    = 1'b1;
            done_next      = 1'b0;
        end else if (ctl.tick) begin
            done_next = 1'b0;
            if (busy) begin
                bit_count_next = bit_count_reg - 8'd1;
                case (phase_reg)
                    PH_BREAK: begin
                        if (last_bit) begin
                            phase_next     = PH_MAB;
                            bit_count_next = mab_len;
                        end
                    end
                    PH_MAB: begin
                        if (last_bit) begin
                            // start code slot
                            phase_next      = PH_SLOTS;
                            slot_shift_next = {2'b11, 8'h00, 1'b0};
                            bit_count_next  = dmxt_pkg::SLOT_BITS;
                            slot_index_next = '0;
                        end
                    end
                    PH_SLOTS: begin
                        slot_shift_next = {1'b1, slot_shift_reg[dmxt_pkg::SLOT_W-1:1]};
                        if (last_bit) begin
                            if (slot_index_reg >= IDX_W'(CHANNELS)) begin
                                phase_next      = PH_IDLE;
                                slot_index_next = '0;
                                slot_shift_next = '1;
                                done_next       = 1'b1;
                            end else begin
                                slot_shift_next = {2'b11, rd_data, 1'b0};
                                bit_count_next  = dmxt_pkg::SLOT_BITS;
                                slot_index_next = slot_index_reg + IDX_W'(1);
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            slot_index_reg <= '0;
            slot_shift_reg <= '1;
            enable_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            slot_index_reg <= slot_index_next;
            slot_shift_reg <= slot_shift_next;
            enable_reg     <= enable_next;
            done_reg       <= done_next;
        end
    end

    always_comb begin
        stat.busy   = busy;
        stat.enable = enable_reg;
        stat.done   = done_reg;
        case (phase_reg)
            PH_BREAK: stat.line = 1'b0;
            PH_SLOTS: stat.line = slot_shift_reg[0];
            default:  stat.line = 1'b1;
        endcase
    end

    // a running phase always has at least the current bit time left
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (bit_count_reg != 8'd0))
        else $error("frame running with empty bit count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy && slot_shift_reg[0]))
        else $error("frame done flagged while line not idle");

endmodule
`default_nettype wire

// ----- hw/rtl/dmx512_transmitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmx512_transmitter
// DMX512 transmitter: channel store, item controller and frame sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the universe memory to zero, one channel per
// cycle, over all CHANNELS channels (512 by default); no item is taken during
// that pass, configuration writes are. Each item then returns exactly one
// result. A set-channel or start item runs an execute and a response step, an
// rgb write adds two write steps (three writes through the single write port
// of the universe memory) and a bit tick a tick step (one registered memory
// read to fetch the next slot). The line advances one bit time per tick item;
// the caller paces ticks at the DMX bit rate.
// ----------------------------------------------------------------------------
module dmx512_transmitter #(
    parameter int CHANNELS = 512
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dmxt_pkg::dmxt_item_t                s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dmxt_pkg::dmxt_result_t                   m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dmxt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [7:0]                          cfg_data
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W  = $clog2(CHANNELS + 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_WR1   = 7'b0001000,
        ST_WR2   = 7'b0010000,
        ST_TICK  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          clr_reg, clr_next;
    dmxt_pkg::dmxt_item_t       item_reg;
    logic                       rejected_reg, rejected_next;
    logic                       m_valid_reg, m_valid_next;
    dmxt_pkg::dmxt_result_t     m_data_reg, m_data_next;
    logic [7:0]                 break_bits_reg, break_bits_next;
    logic [7:0]                 mab_bits_reg, mab_bits_next;

    logic                       s_accept;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_wa;
    logic [7:0]                 ram_wd;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_ra;
    logic [7:0]                 ram_rd;
    dmxt_pkg::dmxt_frame_ctl_t  ctl;
    dmxt_pkg::dmxt_frame_stat_t stat;
    logic                       set_ok;
    logic                       rgb_ok;
    logic [9:0]                 addr_m1;
    logic [9:0]                 addr_p1;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign set_ok  = (item_reg.address != 10'd0)
                   && ({1'b0, item_reg.address} <= 11'(CHANNELS));
    assign rgb_ok  = (item_reg.address != 10'd0)
                   && (({1'b0, item_reg.address} + 11'd2) <= 11'(CHANNELS));
    assign addr_m1 = item_reg.address - 10'd1;
    assign addr_p1 = item_reg.address + 10'd1;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        rejected_next = rejected_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_wa        = '0;
        ram_wd        = '0;
        ram_re        = 1'b0;
        ctl           = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_wa = clr_reg;
                if (clr_reg == ADDR_W'(CHANNELS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (item_reg.mode)
                    dmxt_pkg::MODE_SET: begin
                        rejected_next = stat.busy || !set_ok;
                        ram_we        = !stat.busy && set_ok;
                        ram_wa        = addr_m1[ADDR_W-1:0];
                        ram_wd        = item_reg.level;
                        state_next    = ST_RESP;
                    end
                    dmxt_pkg::MODE_RGB: begin
                        rejected_next = stat.busy || !rgb_ok;
                        ram_we        = !stat.busy && rgb_ok;
                        ram_wa        = addr_m1[ADDR_W-1:0];
                        ram_wd        = item_reg.level;
                        state_next    = (!stat.busy && rgb_ok) ? ST_WR1 : ST_RESP;
                    end
                    dmxt_pkg::MODE_START: begin
                        rejected_next = stat.busy;
                        ctl.start     = !stat.busy;
                        state_next    = ST_RESP;
                    end
                    default: begin
                        // fetch the next slot's level ahead of the tick
                        rejected_next = 1'b0;
                        ram_re        = 1'b1;
                        state_next    = ST_TICK;
                    end
                endcase
            end
            ST_WR1: begin
                ram_we     = 1'b1;
                ram_wa     = item_reg.address[ADDR_W-1:0];
                ram_wd     = item_reg.green;
                state_next = ST_WR2;
            end
            ST_WR2: begin
                ram_we     = 1'b1;
                ram_wa     = addr_p1[ADDR_W-1:0];
                ram_wd     = item_reg.blue;
                state_next = ST_RESP;
            end
            ST_TICK: begin
                ctl.tick   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                m_valid_next              = 1'b1;
                m_data_next.tx_line       = stat.line;
                m_data_next.drive_enable  = stat.enable;
                m_data_next.busy_res      = stat.busy;
                m_data_next.frame_done    = stat.done
                                          && (item_reg.mode == dmxt_pkg::MODE_TICK);
                m_data_next.rejected      = rejected_reg;
                state_next                = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        break_bits_next = break_bits_reg;
        mab_bits_next   = mab_bits_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dmxt_pkg::REG_BREAK_BITS: break_bits_next = cfg_data;
                dmxt_pkg::REG_MAB_BITS:   mab_bits_next   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            rejected_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            break_bits_reg <= 8'd25;
            mab_bits_reg   <= 8'd3;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            rejected_reg   <= rejected_next;
            m_valid_reg    <= m_valid_next;
            break_bits_reg <= break_bits_next;
            mab_bits_reg   <= mab_bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_accept) begin
            item_reg <= s_data;
        end
    end

    dmxt_ram #(
        .WIDTH  (8),
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_universe (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    dmxt_frame #(
        .CHANNELS (CHANNELS),
        .ADDR_W   (ADDR_W),
        .IDX_W    (IDX_W)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .break_bits (break_bits_reg),
        .mab_bits   (mab_bits_reg),
        .rd_data    (ram_rd),
        .rd_addr    (ram_ra),
        .stat       (stat)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("item taken during clearing pass");

    // the universe only changes while no frame is on the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && (state_reg != ST_CLEAR)) |-> !stat.busy)
        else $error("universe written during a frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response step");

endmodule
`default_nettype wire
